// File: rtl/eq2q_pkg.sv
// Shared widths, types and the CORDIC arctangent table for the Euler
// angle to quaternion core. No dependencies.
package eq2q_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = 15;
  localparam int OUT_BITS     = FRAC_BITS + 1;
  localparam int CORDIC_STEPS = 30;
  localparam int NUM_ANGLES   = 3;

  // Angle index within the sample
  localparam int IDX_PITCH = 0;
  localparam int IDX_ROLL  = 1;
  localparam int IDX_YAW   = 2;

  // Residual angle (one turn = 2^33) and Q2.30 rotation vector
  localparam int ZW     = 34;
  localparam int ZSHIFT = 32 - ANGLE_BITS;
  localparam int CW     = 34;
  // Rounded Q30 pair product, Q60 triple product, Q60 sum
  localparam int PW     = CW + 2;
  localparam int MW1    = 2 * CW;
  localparam int MW2    = PW + CW;
  localparam int SW     = MW2 + 1;
  localparam int RSHIFT = 60 - FRAC_BITS;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  typedef logic signed [ZW-1:0]       angle_t;
  typedef logic signed [CW-1:0]       trig_t;
  typedef logic signed [PW-1:0]       pair_t;
  typedef logic signed [OUT_BITS-1:0] quat_t;

  // The arctangent of 2^-i, in units of one turn / 2^33
  function automatic angle_t atan2x(input logic [4:0] idx);
    logic [31:0] t;
    unique case (idx)
      5'd0:  t = 32'h20000000;  5'd1:  t = 32'h12E4051E;
      5'd2:  t = 32'h09FB385B;  5'd3:  t = 32'h051111D4;
      5'd4:  t = 32'h028B0D43;  5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E;  5'd7:  t = 32'h00517C55;
      5'd8:  t = 32'h0028BE53;  5'd9:  t = 32'h00145F2F;
      5'd10: t = 32'h000A2F98;  5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6;  5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2FA;  5'd15: t = 32'h0000517D;
      5'd16: t = 32'h000028BE;  5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30;  5'd19: t = 32'h00000518;
      5'd20: t = 32'h0000028C;  5'd21: t = 32'h00000146;
      5'd22: t = 32'h000000A3;  5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029;  5'd25: t = 32'h00000014;
      5'd26: t = 32'h0000000A;  5'd27: t = 32'h00000005;
      5'd28: t = 32'h00000003;  5'd29: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return angle_t'({t, 1'b0});
  endfunction

endpackage

// File: rtl/eq2q_cordic.sv
// Pipelined rotation-mode CORDIC: one iteration per stage, three angles
// side by side. Depends on eq2q_pkg.
module eq2q_cordic (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_vld,
  input  logic signed [eq2q_pkg::ANGLE_BITS-1:0]  angle [eq2q_pkg::NUM_ANGLES],
  output logic                                    out_vld,
  output eq2q_pkg::trig_t                         cos_val [eq2q_pkg::NUM_ANGLES],
  output eq2q_pkg::trig_t                         sin_val [eq2q_pkg::NUM_ANGLES]
);
  import eq2q_pkg::*;

  logic   vld [CORDIC_STEPS];
  trig_t  xr  [CORDIC_STEPS][NUM_ANGLES];
  trig_t  yr  [CORDIC_STEPS][NUM_ANGLES];
  angle_t zr  [CORDIC_STEPS][NUM_ANGLES];

  genvar i, j;
  generate
    for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
      // Advance the valid bit with the data
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (en) begin
          if (i == 0) vld[i] <= in_vld;
          else        vld[i] <= vld[(i == 0) ? 0 : i-1];
        end
      end

      for (j = 0; j < NUM_ANGLES; j++) begin : g_ang
        trig_t  x_in, y_in;
        angle_t z_in;
        // Stage input: initial vector or previous stage
        always_comb begin
          if (i == 0) begin
            x_in = CORDIC_GAIN;
            y_in = '0;
            z_in = angle_t'(angle[j]) <<< ZSHIFT;
          end else begin
            x_in = xr[(i == 0) ? 0 : i-1][j];
            y_in = yr[(i == 0) ? 0 : i-1][j];
            z_in = zr[(i == 0) ? 0 : i-1][j];
          end
        end
        // Rotate toward zero residual angle
        always_ff @(posedge clk) begin
          if (en) begin
            if (!z_in[ZW-1]) begin
              xr[i][j] <= x_in - (y_in >>> i);
              yr[i][j] <= y_in + (x_in >>> i);
              zr[i][j] <= z_in - atan2x(5'(i));
            end else begin
              xr[i][j] <= x_in + (y_in >>> i);
              yr[i][j] <= y_in - (x_in >>> i);
              zr[i][j] <= z_in + atan2x(5'(i));
            end
          end
        end
      end
    end

    // Take the final rotation vector of each angle
    for (j = 0; j < NUM_ANGLES; j++) begin : g_out
      assign cos_val[j] = xr[CORDIC_STEPS-1][j];
      assign sin_val[j] = yr[CORDIC_STEPS-1][j];
    end
  endgenerate

  assign out_vld = vld[CORDIC_STEPS-1];

endmodule

// File: rtl/eq2q_combine.sv
// Triple products and sums of the half-angle sines and cosines, in three
// register stages, with rounding and saturation. Depends on eq2q_pkg.
module eq2q_combine (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  eq2q_pkg::trig_t        cos_val [eq2q_pkg::NUM_ANGLES],
  input  eq2q_pkg::trig_t        sin_val [eq2q_pkg::NUM_ANGLES],
  output logic                   out_vld,
  output eq2q_pkg::quat_t        qw,
  output eq2q_pkg::quat_t        qx,
  output eq2q_pkg::quat_t        qy,
  output eq2q_pkg::quat_t        qz
);
  import eq2q_pkg::*;

  localparam logic signed [MW1-1:0] HALF30 = MW1'(1) <<< 29;
  localparam logic signed [SW-1:0]  HALFO  = SW'(1) <<< (RSHIFT - 1);
  localparam logic signed [SW-1:0]  QMAX   = (SW'(1) <<< FRAC_BITS) - SW'(1);
  localparam logic signed [SW-1:0]  QMIN   = -(SW'(1) <<< FRAC_BITS);

  logic vld1, vld2;
  pair_t p_cc, p_ss, p_sc, p_cs;
  trig_t cs1, ss1;
  logic signed [MW2-1:0] t_w1, t_w2, t_x1, t_x2, t_y1, t_y2, t_z1, t_z2;

  function automatic pair_t rnd30(input trig_t a, input trig_t b);
    logic signed [MW1-1:0] p;
    logic signed [MW1-1:0] r;
    p = MW1'(a) * MW1'(b);
    r = (p + HALF30) >>> 30;
    return r[PW-1:0];
  endfunction

  function automatic quat_t to_out(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] v;
    quat_t q;
    v = (s + HALFO) >>> RSHIFT;
    priority if (v > QMAX) q = QMAX[OUT_BITS-1:0];
    else if (v < QMIN)     q = QMIN[OUT_BITS-1:0];
    else                   q = v[OUT_BITS-1:0];
    return q;
  endfunction

  // Hold valid bits for the three stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
  end

  // Stage 1: roll by pitch pair products, rounded to Q30
  always_ff @(posedge clk) begin
    if (en) begin
      p_cc <= rnd30(cos_val[IDX_ROLL], cos_val[IDX_PITCH]);
      p_ss <= rnd30(sin_val[IDX_ROLL], sin_val[IDX_PITCH]);
      p_sc <= rnd30(sin_val[IDX_ROLL], cos_val[IDX_PITCH]);
      p_cs <= rnd30(cos_val[IDX_ROLL], sin_val[IDX_PITCH]);
      cs1  <= cos_val[IDX_YAW];
      ss1  <= sin_val[IDX_YAW];
    end
  end

  // Stage 2: multiply by the yaw terms
  always_ff @(posedge clk) begin
    if (en) begin
      t_w1 <= MW2'(p_cc) * MW2'(cs1);
      t_w2 <= MW2'(p_ss) * MW2'(ss1);
      t_x1 <= MW2'(p_sc) * MW2'(cs1);
      t_x2 <= MW2'(p_cs) * MW2'(ss1);
      t_y1 <= MW2'(p_cs) * MW2'(cs1);
      t_y2 <= MW2'(p_sc) * MW2'(ss1);
      t_z1 <= MW2'(p_cc) * MW2'(ss1);
      t_z2 <= MW2'(p_ss) * MW2'(cs1);
    end
  end

  // Stage 3: sum, round and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      qw <= to_out(SW'(t_w1) + SW'(t_w2));
      qx <= to_out(SW'(t_x1) - SW'(t_x2));
      qy <= to_out(SW'(t_y1) + SW'(t_y2));
      qz <= to_out(SW'(t_z1) - SW'(t_z2));
    end
  end

endmodule

// File: rtl/euler_to_quaternion_core.sv
// Euler angle (Z-Y-X) to unit quaternion core.
// Uses eq2q_pkg, eq2q_cordic and eq2q_combine.
//
// Input channel: pitch_angle, roll_angle, yaw_angle with in_valid/in_stall,
// signed binary angles in units of pi/32768. Output channel: quat_w..quat_z,
// signed Q1.15, with out_valid/out_stall. A transfer happens on a clock
// edge where valid is high and stall is low.
// The pipeline has 30 CORDIC iteration stages (all three half angles in
// parallel), one stage of pair products, one of triple products and one
// of sums with rounding and saturation. Throughput is one sample per cycle
// while no stalled result holds the pipeline; every stage is a register
// with a valid bit, and the final stage is the output register.
// When out_stall is high with a result showing, the whole pipeline holds
// and in_stall rises; nothing is dropped or repeated. Bubbles advance
// whenever no result is waiting.
// Synchronous reset clears all valid bits; data registers are not reset.
module euler_to_quaternion_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [eq2q_pkg::ANGLE_BITS-1:0] pitch_angle,
  input  logic signed [eq2q_pkg::ANGLE_BITS-1:0] roll_angle,
  input  logic signed [eq2q_pkg::ANGLE_BITS-1:0] yaw_angle,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output eq2q_pkg::quat_t                        quat_w,
  output eq2q_pkg::quat_t                        quat_x,
  output eq2q_pkg::quat_t                        quat_y,
  output eq2q_pkg::quat_t                        quat_z
);
  import eq2q_pkg::*;

  logic en;
  logic cordic_vld;
  logic signed [ANGLE_BITS-1:0] angle [NUM_ANGLES];
  trig_t cos_val [NUM_ANGLES];
  trig_t sin_val [NUM_ANGLES];

  // Advance unless a finished result is held
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  assign angle[IDX_PITCH] = pitch_angle;
  assign angle[IDX_ROLL]  = roll_angle;
  assign angle[IDX_YAW]   = yaw_angle;

  eq2q_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_valid),
    .angle   (angle),
    .out_vld (cordic_vld),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  eq2q_combine u_combine (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (cordic_vld),
    .cos_val (cos_val),
    .sin_val (sin_val),
    .out_vld (out_valid),
    .qw      (quat_w),
    .qx      (quat_x),
    .qy      (quat_y),
    .qz      (quat_z)
  );

`ifndef NO_ASSERTIONS
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");
  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");
`endif

endmodule

// File: tb/sv/tb_euler_to_quaternion_core.sv
// Testbench for euler_to_quaternion_core: drives attitude samples, predicts
// the quaternion with a bit-exact CORDIC model and checks every transfer.
// Depends on eq2q_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_euler_to_quaternion_core;
  import eq2q_pkg::*;

  localparam int LATENCY   = 33;
  localparam int MAX_CYCLE = 400000;

  typedef struct packed {
    quat_t w;
    quat_t x;
    quat_t y;
    quat_t z;
  } quaternion_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [ANGLE_BITS-1:0] pitch_angle = '0;
  logic signed [ANGLE_BITS-1:0] roll_angle = '0;
  logic signed [ANGLE_BITS-1:0] yaw_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  quat_t quat_w, quat_x, quat_y, quat_z;

  quaternion_t pending_quats[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  euler_to_quaternion_core dut (.*);

  always #5 clk = ~clk;

  // atan(2^-i) in units of one turn / 2^33
  function automatic longint atan_step(int i);
    longint tab[30] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
    return 2 * tab[i];
  endfunction

  // Cosine and sine (Q2.30) of half the binary angle
  function automatic void half_angle_trig(input logic signed [ANGLE_BITS-1:0] ang,
                                          output longint c, output longint s);
    longint z, x, y, dx, dy;
    z = longint'(ang) * (64'sd1 << (32 - ANGLE_BITS));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint triple_prod(longint a, longint b, longint c);
    return ((a * b + (64'sd1 <<< 29)) >>> 30) * c;
  endfunction

  function automatic quat_t to_q15(longint q60);
    longint v;
    v = (q60 + (64'sd1 <<< (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);
    if (v > (64'sd1 <<< FRAC_BITS) - 1) v = (64'sd1 <<< FRAC_BITS) - 1;
    if (v < -(64'sd1 <<< FRAC_BITS)) v = -(64'sd1 <<< FRAC_BITS);
    return quat_t'(v);
  endfunction

  function automatic quaternion_t attitude_quat(logic signed [ANGLE_BITS-1:0] p,
      logic signed [ANGLE_BITS-1:0] r, logic signed [ANGLE_BITS-1:0] yw);
    longint cr, sr, cp, sp, cy, sy;
    quaternion_t q;
    half_angle_trig(r, cr, sr);
    half_angle_trig(p, cp, sp);
    half_angle_trig(yw, cy, sy);
    q.w = to_q15(triple_prod(cr, cp, cy) + triple_prod(sr, sp, sy));
    q.x = to_q15(triple_prod(sr, cp, cy) - triple_prod(cr, sp, sy));
    q.y = to_q15(triple_prod(cr, sp, cy) + triple_prod(sr, cp, sy));
    q.z = to_q15(triple_prod(cr, cp, sy) - triple_prod(sr, sp, cy));
    return q;
  endfunction

  // Send one sample; predict its quaternion at the transfer
  task automatic send_sample(logic signed [ANGLE_BITS-1:0] p,
      logic signed [ANGLE_BITS-1:0] r, logic signed [ANGLE_BITS-1:0] yw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pitch_angle <= p;
    roll_angle <= r;
    yaw_angle <= yw;
    do @(posedge clk); while (in_stall);
    pending_quats.push_back(attitude_quat(p, r, yw));
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result has come
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_quats.size() > 0) @(negedge clk);
  endtask

  // Directed: extremes, wrap points, saturation of the value one
  task automatic test_directed();
    logic signed [ANGLE_BITS-1:0] pts[8] = '{16'sh0000, 16'sh7FFF, -16'sh8000,
      16'sh4000, -16'sh4000, 16'sh0001, -16'sh0001, 16'sh5555};
    for (int i = 0; i < 8; i++) send_sample(pts[i], 16'sh0, 16'sh0);
    for (int i = 0; i < 8; i++) send_sample(16'sh0, pts[i], pts[7 - i]);
    for (int i = 0; i < 8; i++) send_sample(pts[(i + 3) % 8], pts[i], pts[i]);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_sample(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Hold off sending until the pipeline is empty, then resume
  task automatic test_pipeline_drain();
    drain_results();
    test_random(20);
  endtask

  // Receiver stall
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_idle_pct);

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    quaternion_t exp_q;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      if (pending_quats.size() == 0) begin
        $error("unexpected result w=%0d x=%0d y=%0d z=%0d",
               quat_w, quat_x, quat_y, quat_z);
        fail_count++;
      end else begin
        exp_q = pending_quats.pop_front();
        if (quat_w !== exp_q.w) begin
          $error("quat_w expected %0d actual %0d", exp_q.w, quat_w); fail_count++;
        end
        if (quat_x !== exp_q.x) begin
          $error("quat_x expected %0d actual %0d", exp_q.x, quat_x); fail_count++;
        end
        if (quat_y !== exp_q.y) begin
          $error("quat_y expected %0d actual %0d", exp_q.y, quat_y); fail_count++;
        end
        if (quat_z !== exp_q.z) begin
          $error("quat_z expected %0d actual %0d", exp_q.z, quat_z); fail_count++;
        end
      end
    end
    if (cycle_count >= MAX_CYCLE) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 79;
    test_directed();
    test_random(200);
    test_pipeline_drain();
    send_idle_pct = 79;
    recv_idle_pct = 16;
    test_random(220);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(240);
    drain_results();
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending_quats.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
